FILE: rtl/fbrc_pkg.sv
// Package for the page framebuffer rectangle clear/invert core.
// Holds geometry constants, op codes, memory request types and the mask/address helpers.
// No dependencies.
package fbrc_pkg;

  localparam int unsigned PAGES  = 8;
  localparam int unsigned COLS   = 128;
  localparam int unsigned DEPTH  = PAGES * COLS;
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic [7:0] XLIM = 8'((COLS > 255) ? 255 : COLS);
  localparam logic [6:0] YLIM = 7'(((PAGES * 8) > 127) ? 127 : (PAGES * 8));

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_INVERT = 2'd1,
    OP_WRITE  = 2'd2,
    OP_READ   = 2'd3
  } op_e;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic load;
    logic zero;
  } rd_rsp_t;

  function automatic logic [ADDR_W-1:0] byte_addr(input logic [3:0] pg, input logic [7:0] col);
    logic [11:0] a;
    a = 12'(pg) * 12'(COLS) + 12'(col);
    return a[ADDR_W-1:0];
  endfunction

  // y1 is the exclusive bottom row, known to be above y0
  function automatic logic [7:0] page_mask(input logic [3:0] pg, input logic [6:0] y0,
                                           input logic [6:0] y1);
    logic [6:0] yl;
    logic [2:0] lo;
    logic [2:0] hi;
    yl = y1 - 7'd1;
    lo = (pg == y0[6:3]) ? y0[2:0] : 3'd0;
    hi = (pg == yl[6:3]) ? yl[2:0] : 3'd7;
    return (8'hff << lo) & (8'hff >> (3'd7 - hi));
  endfunction

endpackage

FILE: rtl/fbrc_store.sv
// Framebuffer byte store: one write port, one read port with registered data.
// Depends on fbrc_pkg for depth and the request struct.
module fbrc_store (
  input  logic               clk_i,
  input  fbrc_pkg::mem_req_t req_i,
  output logic [7:0]         rd_data_o
);

  logic [7:0] mem [fbrc_pkg::DEPTH];
  logic [7:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rd_q <= mem[req_i.raddr];
    end
  end

  assign rd_data_o = rd_q;

endmodule

FILE: rtl/fbrc_seq.sv
// Sequencer: reset clearing sweep, byte write/read, and the rectangle
// read-modify-write walk over pages and columns. Depends on fbrc_pkg.
module fbrc_seq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         op_i,
  input  logic [7:0]         left_col_i,
  input  logic [6:0]         top_row_i,
  input  logic [7:0]         right_col_i,
  input  logic [6:0]         bottom_row_i,
  input  logic [2:0]         byte_page_i,
  input  logic [6:0]         byte_col_i,
  input  logic [7:0]         byte_data_i,
  input  logic               out_free_i,
  input  logic [7:0]         rd_data_i,
  output fbrc_pkg::mem_req_t mem_req_o,
  output fbrc_pkg::rd_rsp_t  rsp_o
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RECT,
    S_DRAIN,
    S_READ
  } state_e;

  state_e                      state_q, state_d;
  logic [fbrc_pkg::ADDR_W-1:0] ptr_q, ptr_d;
  logic [3:0]                  pg_q, pg_d;
  logic [3:0]                  pg_end_q, pg_end_d;
  logic [7:0]                  col_q, col_d;
  logic [7:0]                  x0_q, x0_d;
  logic [7:0]                  xl_q, xl_d;
  logic [6:0]                  y0_q, y0_d;
  logic [6:0]                  y1_q, y1_d;
  logic                        inv_q, inv_d;
  logic                        pend_q, pend_d;
  logic [fbrc_pkg::ADDR_W-1:0] pend_addr_q, pend_addr_d;
  logic [7:0]                  pend_mask_q, pend_mask_d;
  logic                        zero_q, zero_d;

  logic [7:0] x0c, x1c;
  logic [6:0] y0c, y1c, yl;
  logic       byte_ok;
  logic [fbrc_pkg::ADDR_W-1:0] baddr, raddr;
  logic [7:0] mask, wr_val;

  always_comb begin
    x0c = (left_col_i > fbrc_pkg::XLIM) ? fbrc_pkg::XLIM : left_col_i;
    x1c = (right_col_i > fbrc_pkg::XLIM) ? fbrc_pkg::XLIM : right_col_i;
    y0c = (top_row_i > fbrc_pkg::YLIM) ? fbrc_pkg::YLIM : top_row_i;
    y1c = (bottom_row_i > fbrc_pkg::YLIM) ? fbrc_pkg::YLIM : bottom_row_i;
    yl  = y1c - 7'd1;
    byte_ok = (32'(byte_page_i) < fbrc_pkg::PAGES) && (32'(byte_col_i) < fbrc_pkg::COLS);
    baddr = fbrc_pkg::byte_addr({1'b0, byte_page_i}, {1'b0, byte_col_i});
    raddr = fbrc_pkg::byte_addr(pg_q, col_q);
    mask  = fbrc_pkg::page_mask(pg_q, y0_q, y1_q);
    wr_val = inv_q ? (rd_data_i ^ pend_mask_q) : (rd_data_i & ~pend_mask_q);
  end

  always_comb begin
    state_d     = state_q;
    ptr_d       = ptr_q;
    pg_d        = pg_q;
    pg_end_d    = pg_end_q;
    col_d       = col_q;
    x0_d        = x0_q;
    xl_d        = xl_q;
    y0_d        = y0_q;
    y1_d        = y1_q;
    inv_d       = inv_q;
    pend_d      = pend_q;
    pend_addr_d = pend_addr_q;
    pend_mask_d = pend_mask_q;
    zero_d      = zero_q;
    mem_req_o   = '0;
    rsp_o       = '0;
    in_stall_o  = 1'b1;

    case (state_q)
      S_CLEAR: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = ptr_q;
        mem_req_o.wdata = 8'h00;
        ptr_d = ptr_q + 1'b1;
        if (32'(ptr_q) == fbrc_pkg::DEPTH - 1) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          case (op_i)
            fbrc_pkg::OP_CLEAR, fbrc_pkg::OP_INVERT: begin
              inv_d    = (op_i == fbrc_pkg::OP_INVERT);
              x0_d     = x0c;
              xl_d     = x1c - 8'd1;
              y0_d     = y0c;
              y1_d     = y1c;
              col_d    = x0c;
              pg_d     = y0c[6:3];
              pg_end_d = yl[6:3];
              pend_d   = 1'b0;
              if ((x0c < x1c) && (y0c < y1c)) begin
                state_d = S_RECT;
              end
            end
            fbrc_pkg::OP_WRITE: begin
              mem_req_o.we    = byte_ok;
              mem_req_o.waddr = baddr;
              mem_req_o.wdata = byte_data_i;
            end
            fbrc_pkg::OP_READ: begin
              mem_req_o.re    = byte_ok;
              mem_req_o.raddr = baddr;
              zero_d  = !byte_ok;
              state_d = S_READ;
            end
            default: begin
            end
          endcase
        end
      end
      S_RECT: begin
        mem_req_o.we    = pend_q;
        mem_req_o.waddr = pend_addr_q;
        mem_req_o.wdata = wr_val;
        mem_req_o.re    = 1'b1;
        mem_req_o.raddr = raddr;
        pend_d      = 1'b1;
        pend_addr_d = raddr;
        pend_mask_d = mask;
        if (col_q == xl_q) begin
          col_d = x0_q;
          if (pg_q == pg_end_q) begin
            state_d = S_DRAIN;
          end else begin
            pg_d = pg_q + 4'd1;
          end
        end else begin
          col_d = col_q + 8'd1;
        end
      end
      S_DRAIN: begin
        mem_req_o.we    = pend_q;
        mem_req_o.waddr = pend_addr_q;
        mem_req_o.wdata = wr_val;
        pend_d  = 1'b0;
        state_d = S_IDLE;
      end
      S_READ: begin
        if (out_free_i) begin
          rsp_o.load = 1'b1;
          rsp_o.zero = zero_q;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      ptr_q       <= '0;
      pg_q        <= '0;
      pg_end_q    <= '0;
      col_q       <= '0;
      x0_q        <= '0;
      xl_q        <= '0;
      y0_q        <= '0;
      y1_q        <= '0;
      inv_q       <= 1'b0;
      pend_q      <= 1'b0;
      pend_addr_q <= '0;
      pend_mask_q <= '0;
      zero_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      ptr_q       <= ptr_d;
      pg_q        <= pg_d;
      pg_end_q    <= pg_end_d;
      col_q       <= col_d;
      x0_q        <= x0_d;
      xl_q        <= xl_d;
      y0_q        <= y0_d;
      y1_q        <= y1_d;
      inv_q       <= inv_d;
      pend_q      <= pend_d;
      pend_addr_q <= pend_addr_d;
      pend_mask_q <= pend_mask_d;
      zero_q      <= zero_d;
    end
  end

endmodule

FILE: rtl/page_framebuffer_rect_clear_invert_core.sv
// A write item goes to the store straight from the idle state; a read item moves to S_READ
// and loads the output register, raising out_valid_o, once that register is free, waiting while it is full.
// A rectangle item walks the pages spanned and their columns, one byte read-modify-write per
// cycle, then a last write-back. An empty one leaves the core idle.
// Reset: after rst_ni releases, a clearing pass zeroes all PAGES*COLS = 1024 bytes,
// one per cycle, with in_stall_o high. Depends on fbrc_pkg, fbrc_seq and fbrc_store.
module page_framebuffer_rect_clear_invert_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] op_i,
  input  logic [7:0] left_col_i,
  input  logic [6:0] top_row_i,
  input  logic [7:0] right_col_i,
  input  logic [6:0] bottom_row_i,
  input  logic [2:0] byte_page_i,
  input  logic [6:0] byte_col_i,
  input  logic [7:0] byte_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] read_data_o
);

  fbrc_pkg::mem_req_t mem_req;
  fbrc_pkg::rd_rsp_t  rsp;
  logic [7:0]         rd_data;
  logic               out_free;
  logic               out_valid_q, out_valid_d;
  logic [7:0]         read_data_q, read_data_d;

  assign out_free = !out_valid_q || !out_stall_i;

  fbrc_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .op_i         (op_i),
    .left_col_i   (left_col_i),
    .top_row_i    (top_row_i),
    .right_col_i  (right_col_i),
    .bottom_row_i (bottom_row_i),
    .byte_page_i  (byte_page_i),
    .byte_col_i   (byte_col_i),
    .byte_data_i  (byte_data_i),
    .out_free_i   (out_free),
    .rd_data_i    (rd_data),
    .mem_req_o    (mem_req),
    .rsp_o        (rsp)
  );

  fbrc_store u_store (
    .clk_i     (clk_i),
    .req_i     (mem_req),
    .rd_data_o (rd_data)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    read_data_d = read_data_q;
    if (rsp.load) begin
      out_valid_d = 1'b1;
      read_data_d = rsp.zero ? 8'h00 : rd_data;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      read_data_q <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      read_data_q <= read_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign read_data_o = read_data_q;

  a_load_slot_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.load |-> out_free)
    else $error("result loaded while output slot occupied");

  a_no_result_for_non_read : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && (op_i != fbrc_pkg::OP_READ)) |=> !rsp.load)
    else $error("result produced for a non-read item");

  a_result_while_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without a read in progress");

  a_single_port_use : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_req.we && mem_req.re) |-> (mem_req.waddr != mem_req.raddr))
    else $error("store read and write collide on one address");

endmodule
